[rtl/core/tea_pkg.sv]
`timescale 1ns / 1ps

package tea_pkg;

  // mesh capacity and vertex index width
  localparam int MAX_FACES  = 64;
  localparam int INDEX_BITS = 16;
  localparam int CORNERS    = 3;

  localparam int FACE_W = $clog2(MAX_FACES);
  localparam int CNT_W  = $clog2(MAX_FACES + 1);
  localparam int NB_W   = $clog2(MAX_FACES + 1);

  // one stored triangle and one neighbor row
  typedef logic [CORNERS-1:0][INDEX_BITS-1:0] crow_t;
  typedef logic [CORNERS-1:0][NB_W-1:0]       nb_row_t;

  // input transaction payload
  typedef struct packed {
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic        final_face;
  } tri_in_t;

  // result transaction payload
  typedef struct packed {
    logic [FACE_W-1:0] face_number;
    logic [NB_W-1:0]   edge_ab_neighbor;
    logic [NB_W-1:0]   edge_bc_neighbor;
    logic [NB_W-1:0]   edge_ca_neighbor;
    logic              faces_dropped;
    logic              last_result;
  } tri_out_t;

endpackage

[rtl/core/tea_if.sv]
`timescale 1ns / 1ps

// triangle input channel
interface tea_in_if;
  logic             valid;
  logic             ready;
  tea_pkg::tri_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// adjacency result channel
interface tea_out_if;
  logic              valid;
  logic              ready;
  tea_pkg::tri_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/triangle_edge_adjacency.sv]
`timescale 1ns / 1ps

// Triangle mesh edge adjacency.
// in_tri carries one triangle per transaction (three vertex indices and a
// final_face flag); out_tri returns one result per stored face, in load
// order, with last_result on the final one and faces_dropped set when more
// than MAX_FACES triangles arrived and the extra ones were ignored.
// Loading stores each accepted triangle. After the final triangle the block
// drops in_tri.ready and, with two or more faces stored, runs the pairwise
// edge search on a single shared edge comparator: each face pair (i < j)
// takes a memory read and capture (ST_RD, ST_CAP), 3 to 9 compare steps and
// a write back of row j, and each face i ends with a write back of row i.
// The compare steps test one edge pair per cycle; an edge of face i that
// already has a neighbor is skipped. Each result is then read from the
// neighbor store and presented; while the receiver holds out_tri.ready low
// the result stays on the port and the block waits. After the last result
// is taken the row valid bits, face count and drop flag clear and loading
// resumes. Reset (rst_n low, synchronous) empties the mesh and opens the input.

module triangle_edge_adjacency (
  input  logic        clk,
  input  logic        rst_n,
  tea_in_if.sink      in_tri,
  tea_out_if.source   out_tri
);

  localparam int FW = tea_pkg::FACE_W;
  localparam int CW = tea_pkg::CNT_W;
  localparam int NW = tea_pkg::NB_W;
  localparam int IW = tea_pkg::INDEX_BITS;

  // sequencer codes
  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CAP  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_WBJ  = 3'd4;
  localparam logic [2:0] ST_WBI  = 3'd5;
  localparam logic [2:0] ST_ERD  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  localparam logic [1:0] K_LAST = 2'(tea_pkg::CORNERS - 1);

  // unordered vertex pair of edge k of a face
  function automatic logic [2*IW-1:0] edge_key(tea_pkg::crow_t row, logic [1:0] k);
    logic [1:0]    nk;
    logic [IW-1:0] p;
    logic [IW-1:0] q;
    nk = (k == K_LAST) ? 2'd0 : k + 2'd1;
    p  = row[k];
    q  = row[nk];
    return (p < q) ? {p, q} : {q, p};
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [FW-1:0] i_r, i_nxt;
  logic [FW-1:0] j_r, j_nxt;
  logic [1:0]    ki_r, ki_nxt;
  logic [1:0]    kj_r, kj_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic          newi_r, newi_nxt;
  tea_pkg::nb_row_t nbi_r, nbi_nxt;
  tea_pkg::nb_row_t nbj_r, nbj_nxt;
  logic [tea_pkg::MAX_FACES-1:0] nbv_r, nbv_nxt;

  // memories and their registered read data
  tea_pkg::crow_t   cmem [tea_pkg::MAX_FACES];
  tea_pkg::nb_row_t nmem [tea_pkg::MAX_FACES];
  tea_pkg::crow_t   crd_a_r, crd_b_r;
  tea_pkg::nb_row_t nrd_a_r, nrd_b_r;
  logic             nva_r, nvb_r;

  logic             cw_en;
  logic             nw_en;
  logic [FW-1:0]    nw_addr;
  tea_pkg::nb_row_t nw_data;
  logic [FW-1:0]    nrd_addr;

  logic             room;
  logic [CW-1:0]    cnt_after;
  logic             in_acc;
  logic             out_acc;
  logic             last_face;
  logic             edge_hit;
  tea_pkg::crow_t   in_row;
  tea_pkg::nb_row_t emit_row;

  assign in_row = {in_tri.payload.corner_c[IW-1:0], in_tri.payload.corner_b[IW-1:0],
                   in_tri.payload.corner_a[IW-1:0]};

  assign room      = cnt_r < CW'(tea_pkg::MAX_FACES);
  assign cnt_after = room ? cnt_r + CW'(1) : cnt_r;
  assign in_acc    = in_tri.valid && in_tri.ready;
  assign out_acc   = out_tri.valid && out_tri.ready;
  assign last_face = (CW'(f_r) + CW'(1)) == cnt_r;

  // shared edge comparator
  assign edge_hit = edge_key(crd_a_r, ki_r) == edge_key(crd_b_r, kj_r);

  // corner store: face i on port a, face j on port b
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cmem[cnt_r[FW-1:0]] <= in_row;
    end
    crd_a_r <= cmem[i_r];
    crd_b_r <= cmem[j_r];
  end

  // neighbor store, row valid bits live in flops
  assign nrd_addr = (state_r == ST_ERD || state_r == ST_EMIT) ? f_r : i_r;

  always_ff @(posedge clk) begin
    if (nw_en) begin
      nmem[nw_addr] <= nw_data;
    end
    nrd_a_r <= nmem[nrd_addr];
    nrd_b_r <= nmem[j_r];
    nva_r   <= nbv_r[nrd_addr];
    nvb_r   <= nbv_r[j_r];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ki_nxt    = ki_r;
    kj_nxt    = kj_r;
    f_nxt     = f_r;
    newi_nxt  = newi_r;
    nbi_nxt   = nbi_r;
    nbj_nxt   = nbj_r;
    nbv_nxt   = nbv_r;
    cw_en     = 1'b0;
    nw_en     = 1'b0;
    nw_addr   = j_r;
    nw_data   = nbj_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cw_en   = 1'b1;
            cnt_nxt = cnt_after;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tri.payload.final_face) begin
            i_nxt    = '0;
            j_nxt    = FW'(1);
            f_nxt    = '0;
            newi_nxt = 1'b1;
            state_nxt = (cnt_after >= CW'(2)) ? ST_RD : ST_ERD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        if (newi_r) begin
          nbi_nxt = nva_r ? nrd_a_r : '0;
        end
        nbj_nxt  = nvb_r ? nrd_b_r : '0;
        newi_nxt = 1'b0;
        ki_nxt   = '0;
        kj_nxt   = '0;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (kj_r == 2'd0 && nbi_r[ki_r] != '0) begin
          // edge already has a neighbor, skip its compares
          ki_nxt = ki_r + 2'd1;
          if (ki_r == K_LAST) begin
            state_nxt = ST_WBJ;
          end
        end else begin
          if (edge_hit) begin
            nbi_nxt[ki_r] = NW'(j_r) + NW'(1);
            nbj_nxt[kj_r] = NW'(i_r) + NW'(1);
          end
          if (kj_r == K_LAST) begin
            kj_nxt = '0;
            ki_nxt = ki_r + 2'd1;
            if (ki_r == K_LAST) begin
              state_nxt = ST_WBJ;
            end
          end else begin
            kj_nxt = kj_r + 2'd1;
          end
        end
      end
      ST_WBJ: begin
        nw_en          = 1'b1;
        nw_addr        = j_r;
        nw_data        = nbj_r;
        nbv_nxt[j_r]   = 1'b1;
        if ((CW'(j_r) + CW'(1)) < cnt_r) begin
          j_nxt     = j_r + FW'(1);
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_WBI;
        end
      end
      ST_WBI: begin
        nw_en        = 1'b1;
        nw_addr      = i_r;
        nw_data      = nbi_r;
        nbv_nxt[i_r] = 1'b1;
        if ((CW'(i_r) + CW'(2)) < cnt_r) begin
          i_nxt     = i_r + FW'(1);
          j_nxt     = i_r + FW'(2);
          newi_nxt  = 1'b1;
          state_nxt = ST_RD;
        end else begin
          f_nxt     = '0;
          state_nxt = ST_ERD;
        end
      end
      ST_ERD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_face) begin
            // set delivered, start a fresh mesh
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            nbv_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            f_nxt     = f_r + FW'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      nbv_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      ki_r    <= '0;
      kj_r    <= '0;
      f_r     <= '0;
      newi_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      nbv_r   <= nbv_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ki_r    <= ki_nxt;
      kj_r    <= kj_nxt;
      f_r     <= f_nxt;
      newi_r  <= newi_nxt;
    end
  end

  // working neighbor rows
  always_ff @(posedge clk) begin
    nbi_r <= nbi_nxt;
    nbj_r <= nbj_nxt;
  end

  // ports
  assign emit_row = nva_r ? nrd_a_r : '0;

  assign in_tri.ready                     = (state_r == ST_LOAD);
  assign out_tri.valid                    = (state_r == ST_EMIT);
  assign out_tri.payload.face_number      = f_r;
  assign out_tri.payload.edge_ab_neighbor = emit_row[0];
  assign out_tri.payload.edge_bc_neighbor = emit_row[1];
  assign out_tri.payload.edge_ca_neighbor = emit_row[2];
  assign out_tri.payload.faces_dropped    = ovf_r;
  assign out_tri.payload.last_result      = last_face;

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tri.ready && out_tri.valid))
    else $error("input open while a result is presented");

  // search indices stay ordered and inside the stored set
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (i_r < j_r) && (CW'(j_r) < cnt_r))
    else $error("face pair out of order or beyond stored count");

  // corner counters never reach the unused code
  a_corner_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (ki_r != 2'd3) && (kj_r != 2'd3))
    else $error("corner counter out of range");

  // emitted face is always a stored one
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tri.valid |-> (CW'(f_r) < cnt_r))
    else $error("result for a face that was never stored");

  // the last result clears the mesh
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tri.payload.last_result) |=>
      (cnt_r == '0) && !ovf_r && (nbv_r == '0) && in_tri.ready)
    else $error("mesh state not cleared after the last result");

endmodule
